FILE: rtl/core/swq_pkg.sv
// Package for the semaphore table with wait queues.
// Operation and status codes, result item type and parameter defaults.
// No dependencies.
`default_nettype none

package swq_pkg;

    localparam int DEF_NUM_SEMS    = 16;
    localparam int DEF_NUM_THREADS = 32;
    localparam int DEF_COUNT_BITS  = 16;

    // fixed field widths of the item ports
    localparam int KIND_W   = 2;
    localparam int SIDX_W   = 4;
    localparam int INIT_W   = 16;
    localparam int THR_W    = 5;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] KIND_OPEN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SIDX_W-1:0]   opened_index;
        logic                must_block;
        logic                woken_valid;
        logic [THR_W-1:0]    woken_thread;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/core/swq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module swq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/swq_outreg.sv
// Output register for result items: holds one item until the sink takes it.
// Depends on swq_pkg (t_result).
`default_nettype none

module swq_outreg (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire swq_pkg::t_result i_res,
    input  wire logic             i_ready,
    output logic                  o_valid,
    output swq_pkg::t_result      o_res,
    output logic                  o_free
);

    logic             r_valid;
    swq_pkg::t_result r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

FILE: rtl/core/semaphore_table_with_wait_queues.sv
// Semaphore table with FIFO wait queues: sequencer, open flags, two RAMs.
// Depends on swq_pkg, swq_ram, swq_outreg.
//
//   channel | handshake          | payload
//   --------+--------------------+------------------------------------------------
//   in      | i_valid / o_ready  | i_kind i_sem_index i_init_value i_thread_id
//   out     | o_valid / i_ready  | o_status o_opened_index o_must_block
//           |                    | o_woken_valid o_woken_thread
//
// One item at a time. Wait, failed ops and open on a free cursor slot: accept +
// table read, then modify/write. Signal that pops a waiter with more behind it:
// an extra link RAM read step in between. Open on a taken cursor slot: a
// one-slot-per-cycle scan from slot 0 finds the lowest free slot before the write.
// Reset clears the open flags, cursor and fill count at once; no clearing pass.
// The last step waits while the output register still holds an untaken item.
`default_nettype none

module semaphore_table_with_wait_queues #(
    parameter int NUM_SEMS    = swq_pkg::DEF_NUM_SEMS,
    parameter int NUM_THREADS = swq_pkg::DEF_NUM_THREADS,
    parameter int COUNT_BITS  = swq_pkg::DEF_COUNT_BITS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [swq_pkg::KIND_W-1:0]    i_kind,
    input  wire logic [swq_pkg::SIDX_W-1:0]    i_sem_index,
    input  wire logic [swq_pkg::INIT_W-1:0]    i_init_value,
    input  wire logic [swq_pkg::THR_W-1:0]     i_thread_id,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [swq_pkg::STATUS_W-1:0]  o_status,
    output logic      [swq_pkg::SIDX_W-1:0]    o_opened_index,
    output logic                               o_must_block,
    output logic                               o_woken_valid,
    output logic      [swq_pkg::THR_W-1:0]     o_woken_thread
);

    localparam int SW   = $clog2(NUM_SEMS);
    localparam int TW   = $clog2(NUM_THREADS);
    localparam int CW   = $clog2(NUM_SEMS + 1);
    localparam int MW   = (COUNT_BITS > swq_pkg::INIT_W) ? COUNT_BITS : swq_pkg::INIT_W;
    localparam int SEMW = 1 + COUNT_BITS + 2 * TW;
    localparam int NTAB = 1 << swq_pkg::THR_W;

    localparam logic [COUNT_BITS-1:0] CMAX     = {COUNT_BITS{1'b1}};
    localparam logic [MW-1:0]         CMAX_EXT = MW'(CMAX);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_LINK = 4'b0100,
        S_SCAN = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    logic [swq_pkg::KIND_W-1:0]  r_kind;
    logic [swq_pkg::SIDX_W-1:0]  r_idx;
    logic [swq_pkg::INIT_W-1:0]  r_init;
    logic [TW-1:0]               r_thr;
    logic [NUM_SEMS-1:0]         r_open, n_open;
    logic [SW-1:0]               r_cursor, n_cursor;
    logic [CW-1:0]               r_open_cnt, n_open_cnt;
    logic [SW-1:0]               r_scan, n_scan;

    // thread number modulo NUM_THREADS, as a constant table
    logic [TW-1:0] w_thr_tab [NTAB];
    for (genvar k = 0; k < NTAB; k++) begin : g_thr_tab
        assign w_thr_tab[k] = TW'(k % NUM_THREADS);
    end

    // semaphore RAM word: {nonempty, count, head, tail}
    logic            sem_we, sem_re;
    logic [SW-1:0]   sem_waddr, sem_raddr;
    logic [SEMW-1:0] sem_wdata, sem_rdata;
    logic            lnk_we, lnk_re;
    logic [TW-1:0]   lnk_waddr, lnk_raddr, lnk_wdata, lnk_rdata;

    logic                  w_ne;
    logic [COUNT_BITS-1:0] w_cnt;
    logic [TW-1:0]         w_head, w_tail;

    assign w_ne   = sem_rdata[SEMW-1];
    assign w_cnt  = sem_rdata[SEMW-2 -: COUNT_BITS];
    assign w_head = sem_rdata[2*TW-1:TW];
    assign w_tail = sem_rdata[TW-1:0];

    logic [SW-1:0]         w_sidx;
    logic                  w_idx_ok;
    logic                  w_open_hit;
    logic [MW-1:0]         w_init_ext;
    logic [COUNT_BITS-1:0] w_init_sat;
    logic [SW-1:0]         w_slot;

    assign w_sidx     = SW'(r_idx);
    assign w_idx_ok   = (32'(r_idx) < NUM_SEMS);
    assign w_open_hit = w_idx_ok && r_open[w_sidx];
    assign w_init_ext = MW'(r_init);
    assign w_init_sat = COUNT_BITS'((w_init_ext > CMAX_EXT) ? CMAX_EXT : w_init_ext);
    assign w_slot     = (r_state == S_SCAN) ? r_scan : r_cursor;

    logic             w_load, w_free;
    swq_pkg::t_result w_res, w_out;

    always_comb begin
        n_state    = r_state;
        n_open     = r_open;
        n_cursor   = r_cursor;
        n_open_cnt = r_open_cnt;
        n_scan     = r_scan;
        sem_we     = 1'b0;
        sem_waddr  = w_sidx;
        sem_wdata  = {w_ne, w_cnt, w_head, w_tail};
        sem_re     = 1'b0;
        sem_raddr  = SW'(i_sem_index);
        lnk_we     = 1'b0;
        lnk_waddr  = w_tail;
        lnk_wdata  = r_thr;
        lnk_re     = 1'b0;
        lnk_raddr  = w_head;
        w_load     = 1'b0;
        w_res      = '0;
        o_ready    = (r_state == S_IDLE);

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    sem_re  = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    swq_pkg::KIND_OPEN: begin
                        if (r_open_cnt == CW'(NUM_SEMS)) begin
                            if (w_free) begin
                                w_load       = 1'b1;
                                w_res.status = swq_pkg::ST_FULL;
                                n_state      = S_IDLE;
                            end
                        end else if (r_open[r_cursor]) begin
                            n_scan  = '0;
                            n_state = S_SCAN;
                        end else if (w_free) begin
                            w_load = 1'b1;
                        end
                    end
                    swq_pkg::KIND_SIGNAL, swq_pkg::KIND_WAIT: begin
                        if (!w_open_hit) begin
                            if (w_free) begin
                                w_load       = 1'b1;
                                w_res.status = swq_pkg::ST_CLOSED;
                                n_state      = S_IDLE;
                            end
                        end else if (r_kind == swq_pkg::KIND_SIGNAL) begin
                            if (w_ne && (w_head != w_tail)) begin
                                // more waiters behind the head: fetch its link
                                lnk_re  = 1'b1;
                                n_state = S_LINK;
                            end else if (w_free) begin
                                w_load  = 1'b1;
                                sem_we  = 1'b1;
                                n_state = S_IDLE;
                                if (w_ne) begin
                                    sem_wdata          = {1'b0, w_cnt, w_head, w_tail};
                                    w_res.woken_valid  = 1'b1;
                                    w_res.woken_thread = swq_pkg::THR_W'(w_head);
                                end else if (w_cnt != CMAX) begin
                                    sem_wdata = {w_ne, w_cnt + 1'b1, w_head, w_tail};
                                end
                            end
                        end else if (w_free) begin
                            w_load  = 1'b1;
                            sem_we  = 1'b1;
                            n_state = S_IDLE;
                            if (w_cnt != '0) begin
                                sem_wdata = {w_ne, w_cnt - 1'b1, w_head, w_tail};
                            end else begin
                                w_res.must_block = 1'b1;
                                if (w_ne) begin
                                    lnk_we    = 1'b1;
                                    sem_wdata = {1'b1, w_cnt, w_head, r_thr};
                                end else begin
                                    sem_wdata = {1'b1, w_cnt, r_thr, r_thr};
                                end
                            end
                        end
                    end
                    default: begin
                        if (w_free) begin
                            w_load  = 1'b1;
                            n_state = S_IDLE;
                        end
                    end
                endcase
            end
            S_LINK: begin
                if (w_free) begin
                    w_load             = 1'b1;
                    sem_we             = 1'b1;
                    sem_wdata          = {1'b1, w_cnt, lnk_rdata, w_tail};
                    w_res.woken_valid  = 1'b1;
                    w_res.woken_thread = swq_pkg::THR_W'(w_head);
                    n_state            = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_open[r_scan]) begin
                    n_scan = r_scan + 1'b1;
                end else if (w_free) begin
                    w_load = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // completion of an open, from the cursor slot or from the scan
        if (w_load && (r_kind == swq_pkg::KIND_OPEN) && (r_state != S_IDLE)
                && (r_open_cnt != CW'(NUM_SEMS))) begin
            sem_we               = 1'b1;
            sem_waddr            = w_slot;
            sem_wdata            = {1'b0, w_init_sat, w_head, w_tail};
            n_open[w_slot]       = 1'b1;
            n_cursor             = (w_slot == SW'(NUM_SEMS - 1)) ? '0 : w_slot + 1'b1;
            n_open_cnt           = r_open_cnt + 1'b1;
            w_res.status         = swq_pkg::ST_OK;
            w_res.opened_index   = swq_pkg::SIDX_W'(w_slot);
            n_state              = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_open     <= '0;
            r_cursor   <= '0;
            r_open_cnt <= '0;
            r_scan     <= '0;
        end else begin
            r_state    <= n_state;
            r_open     <= n_open;
            r_cursor   <= n_cursor;
            r_open_cnt <= n_open_cnt;
            r_scan     <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_kind <= i_kind;
            r_idx  <= i_sem_index;
            r_init <= i_init_value;
            r_thr  <= w_thr_tab[i_thread_id];
        end
    end

    // table and links are written only in the last step of an item and read
    // only after the next accept, so accesses never overlap
    swq_ram #(
        .WIDTH(SEMW),
        .DEPTH(NUM_SEMS)
    ) u_sem_ram (
        .i_clk  (i_clk),
        .i_we   (sem_we),
        .i_waddr(sem_waddr),
        .i_wdata(sem_wdata),
        .i_re   (sem_re),
        .i_raddr(sem_raddr),
        .o_rdata(sem_rdata)
    );

    swq_ram #(
        .WIDTH(TW),
        .DEPTH(NUM_THREADS)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lnk_we),
        .i_waddr(lnk_waddr),
        .i_wdata(lnk_wdata),
        .i_re   (lnk_re),
        .i_raddr(lnk_raddr),
        .o_rdata(lnk_rdata)
    );

    swq_outreg u_outreg (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_res  (w_res),
        .i_ready(i_ready),
        .o_valid(o_valid),
        .o_res  (w_out),
        .o_free (w_free)
    );

    assign o_status       = w_out.status;
    assign o_opened_index = w_out.opened_index;
    assign o_must_block   = w_out.must_block;
    assign o_woken_valid  = w_out.woken_valid;
    assign o_woken_thread = w_out.woken_thread;

    a_open_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_open) == 32'(r_open_cnt))
        else $error("open flags and fill count disagree");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("new item taken while one is in work");

    a_scan_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_open_cnt) < NUM_SEMS))
        else $error("free-slot scan with full table");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> w_free)
        else $error("result overwrites an untaken item");

    a_woken_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_woken_valid) |-> (o_status == swq_pkg::ST_OK && !o_must_block))
        else $error("woken thread on a failed or blocking item");

endmodule

`default_nettype wire
